[rtl/wmm_pkg.sv]
// Shared types, constants and the level scaling function for the waveform min/max summary.
package wmm_pkg;

  localparam int POS_W = 25;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] STRIDE_RESET = '0;
  localparam logic [POS_W-1:0] GATE_RESET = 25'd2048;

  localparam int SAMPLE_W = 16;
  localparam int EXT_W = 17;
  localparam int LEVEL_W = 8;
  localparam int INDEX_W = 10;

  // Running extremes are held as 17-bit signed Q2.15 so that +1.0 fits.
  localparam logic signed [EXT_W-1:0] PLUS_ONE = 17'sd32768;
  localparam logic signed [EXT_W-1:0] MINUS_ONE = -17'sd32768;

  localparam int MAX_LINES_DEF = 700;
  localparam int RES_DEPTH = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE = 2'd1;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] min_level;
    logic signed [LEVEL_W-1:0] max_level;
    logic [INDEX_W-1:0]        line_index;
  } result_t;

  // Multiplies a Q2.15 value by 127 and divides by 32768, truncating toward zero.
  function automatic logic signed [LEVEL_W-1:0] scale_level(input logic signed [EXT_W-1:0] v);
    logic signed [23:0] p;
    logic [23:0]        mag;
    logic [8:0]         q;
    p   = $signed({{7{v[EXT_W-1]}}, v}) * 24'sd127;
    mag = p[23] ? 24'(-p) : 24'(p);
    q   = mag[23:15];
    scale_level = p[23] ? $signed(8'(-q[7:0])) : $signed(q[7:0]);
  endfunction

endpackage

[rtl/wmm_core.sv]
// Window state, configuration registers and per-sample min/max update.
module wmm_core #(
  parameter int MAX_LINES = wmm_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [wmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmm_pkg::POS_W-1:0]           cfg_data,
  input  logic                                item_valid,
  input  logic signed [wmm_pkg::SAMPLE_W-1:0] item_sample,
  output logic                                res_push,
  output wmm_pkg::result_t                    res_data
);

  localparam int CNT_W = $clog2(MAX_LINES + 1);

  logic [wmm_pkg::POS_W-1:0] stride_length;
  logic [wmm_pkg::POS_W-1:0] gate_limit;

  logic [wmm_pkg::POS_W-1:0]        window_position, window_position_next;
  logic signed [wmm_pkg::EXT_W-1:0] running_min, running_min_next;
  logic signed [wmm_pkg::EXT_W-1:0] running_max, running_max_next;
  logic [CNT_W-1:0]                 lines_emitted, lines_emitted_next;

  logic                             done;
  logic                             emit;
  logic [wmm_pkg::POS_W-1:0]        pos_base;
  logic signed [wmm_pkg::EXT_W-1:0] min_base;
  logic signed [wmm_pkg::EXT_W-1:0] max_base;
  logic signed [wmm_pkg::EXT_W-1:0] s_ext;
  logic                             gated;
  logic [CNT_W+wmm_pkg::INDEX_W-1:0] lines_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_length <= wmm_pkg::STRIDE_RESET;
      gate_limit    <= wmm_pkg::GATE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wmm_pkg::REG_STRIDE: stride_length <= cfg_data;
        wmm_pkg::REG_GATE:   gate_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    done     = lines_emitted >= CNT_W'(MAX_LINES);
    emit     = item_valid && !done && (window_position >= stride_length);
    pos_base = emit ? '0 : window_position;
    min_base = emit ? wmm_pkg::PLUS_ONE : running_min;
    max_base = emit ? wmm_pkg::MINUS_ONE : running_max;
    s_ext    = $signed({item_sample[wmm_pkg::SAMPLE_W-1], item_sample});
    gated    = pos_base <= gate_limit;

    running_min_next     = (gated && (s_ext < min_base)) ? s_ext : min_base;
    running_max_next     = (gated && (s_ext > max_base)) ? s_ext : max_base;
    window_position_next = (pos_base < wmm_pkg::POS_MAX) ? pos_base + 1'b1 : pos_base;
    lines_emitted_next   = emit ? lines_emitted + 1'b1 : lines_emitted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_position <= '0;
      running_min     <= wmm_pkg::PLUS_ONE;
      running_max     <= wmm_pkg::MINUS_ONE;
      lines_emitted   <= '0;
    end else if (item_valid && !done) begin
      window_position <= window_position_next;
      running_min     <= running_min_next;
      running_max     <= running_max_next;
      lines_emitted   <= lines_emitted_next;
    end
  end

  assign lines_wide = {{wmm_pkg::INDEX_W{1'b0}}, lines_emitted};

  assign res_push            = emit;
  assign res_data.min_level  = wmm_pkg::scale_level(running_min);
  assign res_data.max_level  = wmm_pkg::scale_level(running_max);
  assign res_data.line_index = lines_wide[wmm_pkg::INDEX_W-1:0];

endmodule

[rtl/wmm_result_fifo.sv]
// Small result queue that separates the compute stage from the output handshake.
module wmm_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wmm_pkg::result_t push_data,
  input  logic             pop,
  output logic             not_empty,
  output wmm_pkg::result_t head,
  output logic [1:0]       count
);

  localparam int PTR_W = $clog2(wmm_pkg::RES_DEPTH);

  wmm_pkg::result_t entry [wmm_pkg::RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [1:0]       fill, fill_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(wmm_pkg::RES_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    fill_next = fill;
    if (push && !pop) fill_next = fill + 1'b1;
    else if (pop && !push) fill_next = fill - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  assign not_empty = fill != '0;
  assign head      = entry[rd_ptr];
  assign count     = fill;

endmodule

[rtl/waveform_min_max_summary_top.sv]
// Top level of the waveform min/max summary block.
// The block accepts one signed Q1.15 sample per clock cycle while in_stall is
// low and emits at most one summary line per sample. A sample is registered
// in an input stage, then a single pass of compare logic updates the window
// position, the running minimum and maximum and the line counter, and a
// finished line is pushed into a three-entry result queue. A line passes the
// input stage register and the result queue before it is offered on the
// output. in_stall is raised only when the queue plus the sample in the
// input stage could fill the queue, so with an output that is not stalled
// the sustained rate is one transaction per cycle. Configuration writes are
// always taken (cfg_ready is high) and must only be issued while the block
// is idle.
module waveform_min_max_summary_top #(
  parameter int MAX_LINES = wmm_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wmm_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wmm_pkg::LEVEL_W-1:0]  min_level,
  output logic signed [wmm_pkg::LEVEL_W-1:0]  max_level,
  output logic [wmm_pkg::INDEX_W-1:0]         line_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmm_pkg::POS_W-1:0]           cfg_data
);

  // Input stage register.
  logic                                s1_valid;
  logic signed [wmm_pkg::SAMPLE_W-1:0] s1_sample;

  logic             res_push;
  wmm_pkg::result_t res_data;
  wmm_pkg::result_t head;
  logic [1:0]       q_count;
  logic [2:0]       committed;
  logic             pop;

  // Every result in flight already has a reserved queue slot, so the queue
  // can never overflow.
  assign committed = {1'b0, q_count} + {2'b00, s1_valid};
  assign in_stall  = committed >= 3'(wmm_pkg::RES_DEPTH);
  assign cfg_ready = 1'b1;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_sample <= sample;
  end

  wmm_core #(
    .MAX_LINES(MAX_LINES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (s1_valid),
    .item_sample(s1_sample),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  wmm_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res_data),
    .pop      (pop),
    .not_empty(out_valid),
    .head     (head),
    .count    (q_count)
  );

  assign min_level  = head.min_level;
  assign max_level  = head.max_level;
  assign line_index = head.line_index;

endmodule

[rtl/wmm_checker.sv]
// Port-level assertions for the waveform min/max summary block, bound to the top level.
module wmm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [wmm_pkg::LEVEL_W-1:0]  min_level,
  input logic signed [wmm_pkg::LEVEL_W-1:0]  max_level,
  input logic [wmm_pkg::INDEX_W-1:0]         line_index
);

  logic [31:0] in_count;
  logic [31:0] out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
    end else begin
      if (in_valid && !in_stall)   in_count  <= in_count + 1'b1;
      if (out_valid && !out_stall) out_count <= out_count + 1'b1;
    end
  end

  // A stalled line holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_level) && $stable(max_level)
      && $stable(line_index))
    else $error("stalled output line changed");

  // Lines are numbered consecutively from zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_index == out_count[wmm_pkg::INDEX_W-1:0])
    else $error("line index out of sequence");

  // Every line is caused by an earlier sample.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count < in_count)
    else $error("line emitted without a sample");

  // A window either saw samples or is the empty marker.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_level <= max_level)
      || (min_level == 8'sd127 && max_level == -8'sd127))
    else $error("inconsistent min and max levels");

endmodule

bind waveform_min_max_summary_top wmm_checker u_wmm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .min_level (min_level),
  .max_level (max_level),
  .line_index(line_index)
);

[test/waveform_min_max_summary_monitor.sv]
// Monitor that predicts the summary lines of the waveform min/max block and checks them.
`timescale 1ns / 1ps

module waveform_min_max_summary_monitor #(
  parameter int MAX_LINES = wmm_pkg::MAX_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [wmm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [wmm_pkg::LEVEL_W-1:0]  min_level,
  input  logic signed [wmm_pkg::LEVEL_W-1:0]  max_level,
  input  logic [wmm_pkg::INDEX_W-1:0]         line_index,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [wmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmm_pkg::POS_W-1:0]           cfg_data,
  output int                                  errors,
  output int                                  outstanding
);

  localparam int LEVEL_SCALE = 127;
  localparam int Q15_ONE = 32768;

  logic [wmm_pkg::POS_W-1:0]        stride_len;
  logic [wmm_pkg::POS_W-1:0]        gate_pos;
  logic [wmm_pkg::POS_W-1:0]        win_pos;
  logic signed [wmm_pkg::EXT_W-1:0] win_min;
  logic signed [wmm_pkg::EXT_W-1:0] win_max;
  int                               lines_done;
  wmm_pkg::result_t                 pending_lines[$];

  // Scales a Q2.15 extreme to a level in [-127, 127], truncating toward zero.
  function automatic logic signed [wmm_pkg::LEVEL_W-1:0] to_level(
    input logic signed [wmm_pkg::EXT_W-1:0] v);
    int prod;
    int quo;
    prod = int'(v) * LEVEL_SCALE;
    if (prod < 0) begin
      quo = -((-prod) / Q15_ONE);
    end else begin
      quo = prod / Q15_ONE;
    end
    return wmm_pkg::LEVEL_W'(quo);
  endfunction

  // Advances the window by one sample and queues the line it closes, if any.
  task automatic summarize_sample(input logic signed [wmm_pkg::SAMPLE_W-1:0] s);
    wmm_pkg::result_t done_line;
    if (lines_done >= MAX_LINES) return;
    if (win_pos >= stride_len) begin
      done_line.min_level  = to_level(win_min);
      done_line.max_level  = to_level(win_max);
      done_line.line_index = wmm_pkg::INDEX_W'(lines_done);
      pending_lines.push_back(done_line);
      lines_done++;
      win_pos = '0;
      win_min = wmm_pkg::PLUS_ONE;
      win_max = wmm_pkg::MINUS_ONE;
    end
    if (win_pos <= gate_pos) begin
      if (s > win_max) win_max = s;
      if (s < win_min) win_min = s;
    end
    if (win_pos != wmm_pkg::POS_MAX) win_pos++;
  endtask

  task automatic report_field(input string what, input int idx,
                              input logic signed [31:0] want_v,
                              input logic signed [31:0] got_v, inout int bad);
    if (want_v !== got_v) begin
      $display("%0t: line %0d %s expected %0d, got %0d", $time, idx, what, want_v, got_v);
      bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    wmm_pkg::result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      stride_len = wmm_pkg::STRIDE_RESET;
      gate_pos   = wmm_pkg::GATE_RESET;
      win_pos    = '0;
      win_min    = wmm_pkg::PLUS_ONE;
      win_max    = wmm_pkg::MINUS_ONE;
      lines_done = 0;
      pending_lines.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wmm_pkg::REG_STRIDE: stride_len = cfg_data;
          wmm_pkg::REG_GATE:   gate_pos = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) summarize_sample(sample);
      if (out_valid && !out_stall) begin
        if (pending_lines.size() == 0) begin
          $display("%0t: unexpected line %0d (min_level %0d, max_level %0d), none expected",
                   $time, line_index, min_level, max_level);
          bad++;
        end else begin
          want = pending_lines.pop_front();
          report_field("min_level", want.line_index, $signed(want.min_level), min_level, bad);
          report_field("max_level", want.line_index, $signed(want.max_level), max_level, bad);
          report_field("line_index", want.line_index, want.line_index, line_index, bad);
        end
      end
    end
    errors      <= errors + bad;
    outstanding <= pending_lines.size();
  end

endmodule

[test/waveform_min_max_summary_top_tb.sv]
// Testbench top for the waveform min/max summary: stimulus, reset, idling and the verdict.
`timescale 1ns / 1ps

module waveform_min_max_summary_top_tb;

  // The line budget is shared by the whole run, since reset is applied only once.
  localparam int LINE_LIMIT = wmm_pkg::MAX_LINES_DEF;
  localparam int RANDOM_ITEMS = 100;
  // Random phases stop this many lines short of the budget so that the final
  // phase is the one that runs the block out of lines.
  localparam int LINE_MARGIN = 120;
  localparam int EXTRA_IGNORED = 30;
  // A line passes the input stage register and the result queue before output;
  // this covers a sample that closes no window and may still sit in the pipeline.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_WAIT = 17;
  localparam logic [wmm_pkg::POS_W-1:0] STRIDE_TOP = 25'd16777216;
  localparam logic [wmm_pkg::POS_W-1:0] GATE_TOP = 25'd16777216;
  // Index 3 maps to no register; writes to it must leave the block unchanged.
  localparam logic [wmm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [wmm_pkg::SAMPLE_W-1:0] FULL_POS = 16'sh7FFF;
  localparam logic signed [wmm_pkg::SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [wmm_pkg::SAMPLE_W-1:0] sample;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [wmm_pkg::LEVEL_W-1:0]  min_level;
  logic signed [wmm_pkg::LEVEL_W-1:0]  max_level;
  logic [wmm_pkg::INDEX_W-1:0]         line_index;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [wmm_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [wmm_pkg::POS_W-1:0]           cfg_data;

  int mismatches;
  int outstanding;

  // Lines taken by the receiver so far; exact whenever the block is drained.
  int lines_seen = 0;
  // When set, the matching side runs without any idle cycles.
  bit sender_burst = 1'b0;
  bit recv_burst = 1'b0;

  int                                  items_sent;
  int                                  phase_len;
  int                                  tail_len;
  int                                  i;
  logic [wmm_pkg::POS_W-1:0]           stride_pick;
  logic [wmm_pkg::POS_W-1:0]           gate_pick;
  logic signed [wmm_pkg::SAMPLE_W-1:0] sample_pick;

  waveform_min_max_summary_top #(
    .MAX_LINES(LINE_LIMIT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .min_level (min_level),
    .max_level (max_level),
    .line_index(line_index),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  waveform_min_max_summary_monitor #(
    .MAX_LINES(LINE_LIMIT)
  ) line_monitor (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .min_level  (min_level),
    .max_level  (max_level),
    .line_index (line_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (mismatches),
    .outstanding(outstanding)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Safety net: a hung handshake or a line that never shows up ends here.
  initial begin
    #2_000_000;
    $display("waveform_min_max_summary_top_tb: done, errors");
    $finish;
  end

  // Offers one sample after a random idle gap and returns at the edge where
  // the transaction is taken. in_valid is left high so that back-to-back
  // samples keep it asserted without a glitch.
  task automatic send_sample(input logic signed [wmm_pkg::SAMPLE_W-1:0] value);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Issues one register write; cfg_valid stays high for a following write.
  task automatic write_reg(input logic [wmm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wmm_pkg::POS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  // Writes both registers and, if asked, the unmapped index with random data.
  // Only called while the block is drained.
  task automatic configure(input logic [wmm_pkg::POS_W-1:0] stride,
                           input logic [wmm_pkg::POS_W-1:0] gate, input bit spare);
    write_reg(wmm_pkg::REG_STRIDE, stride);
    write_reg(wmm_pkg::REG_GATE, gate);
    if (spare) write_reg(REG_SPARE, wmm_pkg::POS_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Holds off the sender until every predicted line has been taken, then lets
  // the pipeline settle. The first edge lets the monitor's count catch up with
  // a sample taken at the current edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: before each line it draws a random stall unless recv_burst is set,
  // then takes the next line that is offered. Stalls also fall on idle stretches.
  initial begin : receiver
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      lines_seen++;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    sample    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= wmm_pkg::REG_STRIDE;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: stride zero, so every sample closes the previous window.
    // The very first line comes from a window that saw no sample at all and
    // must read +127 / -127. The rest carry one extreme sample each.
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh4000);
    wait_drained();

    // Narrow gate: only the first two positions of each window count, so the
    // full-scale samples later in the window must not reach the extremes.
    configure(25'd4, 25'd1, 1'b0);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample(16'sd7);
    send_sample(-16'sd7);
    send_sample(FULL_NEG);
    send_sample(FULL_POS);
    wait_drained();

    // Gate at zero with an odd stride, plus a write to the unmapped index.
    configure(25'd3, 25'd0, 1'b1);
    send_sample(-16'sd5);
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample(16'sd9);
    send_sample(FULL_NEG);
    send_sample(FULL_POS);
    wait_drained();

    // Both registers at 2^24: the window keeps growing, no line.
    configure(STRIDE_TOP, GATE_TOP, 1'b0);
    send_sample(FULL_NEG);
    send_sample(FULL_POS);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    wait_drained();

    // Dropping the stride under the current position closes the long window
    // on the next sample.
    configure(25'd2, GATE_TOP, 1'b0);
    send_sample(16'sd1234);
    send_sample(-16'sd1234);
    wait_drained();

    // Random phases: each picks a stride and a gate, then streams samples with
    // random content. Mostly small even strides, with zero, one, short, long and
    // 2^24 mixed in, and gates that fall inside and outside the window.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS && lines_seen < LINE_LIMIT - LINE_MARGIN) begin
      case ($urandom_range(0, 9))
        0:       stride_pick = '0;
        1:       stride_pick = 25'd1;
        7:       stride_pick = wmm_pkg::POS_W'($urandom_range(1, 40));
        8:       stride_pick = wmm_pkg::POS_W'($urandom_range(64, 300));
        9:       stride_pick = STRIDE_TOP;
        default: stride_pick = wmm_pkg::POS_W'(2 * $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       gate_pick = '0;
        1:       gate_pick = GATE_TOP;
        2:       gate_pick = wmm_pkg::POS_W'($urandom_range(0, GATE_TOP));
        5:       gate_pick = stride_pick >> 1;
        default: gate_pick = wmm_pkg::POS_W'($urandom_range(0, stride_pick + 1));
      endcase
      configure(stride_pick, gate_pick, $urandom_range(0, 3) == 0);
      sender_burst = ($urandom_range(0, 2) == 0);
      recv_burst   = ($urandom_range(0, 2) == 0);
      phase_len    = $urandom_range(20, 70);
      for (i = 0; i < phase_len; i++) begin
        // Full-scale values, small values around zero that keep the extremes
        // close together, and fully random words that toggle every bit.
        case ($urandom_range(0, 9))
          0:       sample_pick = FULL_POS;
          1:       sample_pick = FULL_NEG;
          2, 3:    sample_pick = wmm_pkg::SAMPLE_W'($urandom_range(0, 512) - 256);
          default: sample_pick = wmm_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
        send_sample(sample_pick);
        // Now and then the sender waits mid-phase for every line to arrive.
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
      items_sent += phase_len;
      wait_drained();
    end

    // Final phase: stride zero gives one line per sample, which runs the block
    // out of lines. The samples after that must be dropped without a line.
    configure('0, wmm_pkg::POS_W'($urandom_range(0, GATE_TOP)), 1'b1);
    sender_burst = ($urandom_range(0, 1) == 0);
    recv_burst   = ($urandom_range(0, 1) == 0);
    tail_len     = LINE_LIMIT - lines_seen + EXTRA_IGNORED;
    for (i = 0; i < tail_len; i++) begin
      send_sample(wmm_pkg::SAMPLE_W'($urandom_range(0, 65535)));
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("waveform_min_max_summary_top_tb: done, clean");
    end else begin
      $display("waveform_min_max_summary_top_tb: done, errors");
    end
    $finish;
  end

endmodule
